FILE: design/sms_pkg.sv
// Package for the stepper move sequencer: codes, defaults, state and result types.
// No dependencies; used by sms_core and stepper_move_sequencer_top.
package sms_pkg;

    localparam int STARTUP_PULSES_DEF = 25;
    localparam int TAIL_PULSES_DEF    = 10;
    localparam int SPEED_LEVELS_DEF   = 10;

    localparam logic       ACT_TICK  = 1'b0;
    localparam logic       ACT_START = 1'b1;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_WEIGH = 2'd1;
    localparam logic [1:0] MODE_STORE = 2'd2;
    localparam logic [1:0] MODE_BOTH  = 2'd3;

    localparam logic       CFG_SPEED_LEVEL = 1'b0;
    localparam logic       CFG_SENSORS_EN  = 1'b1;

    typedef struct packed {
        logic [7:0] remaining;
        logic [5:0] slow_left;
        logic       hold_power;
        logic       closure_seen;
        logic [1:0] mode;
        logic       running;
        logic [1:0] enables;      // bit0 weigh, bit1 store
        logic [1:0] status;       // bit0 store, bit1 weigh
    } t_state;

    typedef struct packed {
        logic [3:0] speed_level;
        logic       sensors_en;
    } t_cfg;

    typedef struct packed {
        logic       action;
        logic [1:0] motor_mode;
        logic [7:0] pulse_count;
        logic       keep_powered;
        logic       weigh_closed;
        logic       store_closed;
    } t_item;

    typedef struct packed {
        logic       rejected;
        logic [3:0] speed;
        logic       step;
    } t_res;

endpackage

FILE: design/sms_core.sv
// Next-state and result logic of the stepper move sequencer for one beat.
// Uses sms_pkg types; purely combinational, registered by the top level.
module sms_core #(
    parameter int STARTUP_PULSES = sms_pkg::STARTUP_PULSES_DEF,
    parameter int TAIL_PULSES    = sms_pkg::TAIL_PULSES_DEF,
    parameter int SPEED_LEVELS   = sms_pkg::SPEED_LEVELS_DEF
) (
    input  sms_pkg::t_state i_state,
    input  sms_pkg::t_cfg   i_cfg,
    input  sms_pkg::t_item  i_item,
    output sms_pkg::t_state o_state,
    output sms_pkg::t_res   o_res
);

    localparam logic [5:0] StartCnt  = 6'(STARTUP_PULSES);
    localparam logic [7:0] TailCnt   = 8'(TAIL_PULSES);
    localparam logic [4:0] SpeedLim  = 5'(SPEED_LEVELS);

    logic [7:0] rem_dec;
    logic       cut_hit;

    assign rem_dec = i_state.remaining - 8'd1;
    assign cut_hit = ((i_state.mode == sms_pkg::MODE_WEIGH) && i_item.weigh_closed) ||
                     ((i_state.mode == sms_pkg::MODE_STORE) && i_item.store_closed);

    always_comb begin
        o_state = i_state;
        o_res   = '0;
        if (i_item.action == sms_pkg::ACT_START) begin
            if ({1'b0, i_cfg.speed_level} >= SpeedLim) begin
                o_res.rejected = 1'b1;
            end else begin
                o_state.remaining    = i_item.pulse_count;
                o_state.slow_left    = StartCnt;
                o_state.hold_power   = i_item.keep_powered;
                o_state.closure_seen = 1'b0;
                o_state.mode         = i_item.motor_mode;
                o_state.enables      = i_item.motor_mode;
                o_state.running      = 1'b1;
                o_res.speed          = i_cfg.speed_level;
            end
        end else if (i_state.running) begin
            if (i_state.remaining != 8'd0) begin
                o_state.remaining = rem_dec;
                if (i_state.slow_left != 6'd0) begin
                    o_state.slow_left = i_state.slow_left - 6'd1;
                end else begin
                    o_res.speed = i_cfg.speed_level;
                end
                o_res.step = 1'b1;
                if (i_cfg.sensors_en && !i_state.hold_power) begin
                    // closure of the driven motor trims the move to its tail
                    if (cut_hit && (rem_dec > TailCnt)) begin
                        o_state.remaining = TailCnt;
                    end
                    if (i_item.weigh_closed || i_item.store_closed) begin
                        o_state.closure_seen = 1'b1;
                    end
                end
            end else begin
                // finishing tick
                if (i_cfg.sensors_en) begin
                    if (i_state.mode == sms_pkg::MODE_STORE) begin
                        o_state.status[0] = !i_state.closure_seen;
                    end
                    if (i_state.mode == sms_pkg::MODE_WEIGH) begin
                        o_state.status[1] = !i_state.closure_seen;
                    end
                end
                if (!i_state.hold_power) begin
                    o_state.enables = 2'b00;
                end
                o_state.running = 1'b0;
            end
        end
    end

endmodule

FILE: design/stepper_move_sequencer_top.sv
// Top level of the stepper move sequencer: stream ports, config registers, state.
// Depends on sms_pkg and sms_core.

// Each input beat is a timer tick or a start command and yields exactly one result
// beat. A beat is taken every cycle while the output register is empty or being
// drained; its result is in the output register in the cycle after acceptance.
// Sequencer state updates at the accept edge; a configuration write takes effect
// for beats accepted after its edge. The rate is one beat per clock while the
// output is not stalled, set by the single output register stage.
module stepper_move_sequencer_top #(
    parameter int STARTUP_PULSES = sms_pkg::STARTUP_PULSES_DEF,
    parameter int TAIL_PULSES    = sms_pkg::TAIL_PULSES_DEF,
    parameter int SPEED_LEVELS   = sms_pkg::SPEED_LEVELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] motor_mode, [9:2] pulse_count, [10] keep_powered,
    // [11] weigh_closed, [12] store_closed, [15:13] zero
    input  logic [15:0] s_axis_tdata,
    // [0] action
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] step_pulse, [4:1] speed_select, [5] weigh_enable, [6] store_enable,
    // [7] busy_res, [15:8] pulses_left, [17:16] missed_closure,
    // [18] start_rejected, [23:19] zero
    output logic [23:0] m_axis_tdata
);

    sms_pkg::t_state r_state, n_state;
    sms_pkg::t_cfg   r_cfg;
    sms_pkg::t_item  in_item;
    sms_pkg::t_res   n_res;
    logic            r_out_valid;
    logic [23:0]     r_out_data;
    logic            in_fire;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign in_item.action       = s_axis_tuser;
    assign in_item.motor_mode   = s_axis_tdata[1:0];
    assign in_item.pulse_count  = s_axis_tdata[9:2];
    assign in_item.keep_powered = s_axis_tdata[10];
    assign in_item.weigh_closed = s_axis_tdata[11];
    assign in_item.store_closed = s_axis_tdata[12];

    sms_core #(
        .STARTUP_PULSES (STARTUP_PULSES),
        .TAIL_PULSES    (TAIL_PULSES),
        .SPEED_LEVELS   (SPEED_LEVELS)
    ) u_core (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_item  (in_item),
        .o_state (n_state),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_level <= 4'd0;
            r_cfg.sensors_en  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sms_pkg::CFG_SPEED_LEVEL: r_cfg.speed_level <= i_cfg_wdata;
                sms_pkg::CFG_SENSORS_EN:  r_cfg.sensors_en  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= {5'd0, n_res.rejected, n_state.status, n_state.remaining,
                           n_state.running, n_state.enables[1], n_state.enables[0],
                           n_res.speed, n_res.step};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // an idle sequencer never holds leftover pulses
    a_idle_no_pulses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.running |-> (r_state.remaining == 8'd0))
        else $error("idle with pulses left");

    a_slow_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.slow_left <= 6'(STARTUP_PULSES))
        else $error("slow-start count out of range");

    // a step beat always leaves the sequencer busy
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[0]) |-> r_out_data[7])
        else $error("step issued while not busy");

    a_start_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (s_axis_tuser == sms_pkg::ACT_START) &&
         ({1'b0, r_cfg.speed_level} < 5'(SPEED_LEVELS)))
        |=> (r_state.running && (r_state.remaining == $past(s_axis_tdata[9:2]))))
        else $error("start did not load the move");

endmodule
